FILE: sv/swmt_pkg.sv
// swmt_pkg: shared constants for the sliding window mean tracker
// no dependencies; imported by the top level and its port checker
`default_nettype none

package swmt_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // configuration port
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_FULL   = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(20);

endpackage

`default_nettype wire

FILE: sv/sliding_window_mean_tracker_unit.sv
// Sliding window mean tracker: ring of samples, running sum, bit-serial divider
// depends on swmt_pkg; checked by swmt_checker in swmt_checker.sv
//
// Boxcar moving average over the last window_length samples (signed, 8 fraction
// bits). Each accepted sample beat yields one result beat: the window mean
// truncated toward zero, the sample minus that mean, the change of the mean
// since the previous beat, and a window-full flag. The sample goes through a
// ring update, a running-sum update and a restoring divider that retires one
// quotient bit per cycle; in_ready_o stays low from acceptance until the result
// is loaded into the output register, which waits while that register still
// holds an unaccepted result. The result sits in an output register, so the
// next sample can be accepted while it waits. Writing window_length
// (index 0) clears the window; divide_by_full_window (index 1) selects the
// divisor. Configuration is written while the block is idle.
`default_nettype none

module sliding_window_mean_tracker_unit
  import swmt_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      window_mean_o,
  output logic signed [SAMPLE_BITS:0]        sample_minus_mean_o,
  output logic signed [SAMPLE_BITS:0]        mean_change_o,
  output logic                               window_full_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned LenCap = (MAX_WINDOW > 255) ? 255 : MAX_WINDOW;
  localparam logic [CNT_W-1:0]  LEN_CAP   = CNT_W'(LenCap);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]              wlen_q;
  logic                          div_full_q;
  logic [CNT_W-1:0]              len;
  logic [CNT_W-1:0]              fill_q;
  logic [IDX_W-1:0]              oldest_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SUM_W-1:0]       sum_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic signed [SAMPLE_BITS-1:0] prev_mean_q;
  logic                          full;
  logic                          out_load;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic [IDX_W-1:0]              ram_waddr;
  logic [IDX_W-1:0]              oldest_next;

  // bit-serial divider
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  den_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W-1:0]  rem_d;

  assign len = (wlen_q == '0) ? CNT_W'(1) : ((wlen_q > LEN_CAP) ? LEN_CAP : wlen_q);
  assign full = (fill_q == len);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // result register free or draining this cycle
  assign out_load = (state_q == S_OUT) && (!out_valid_o || out_ready_i);

  assign ram_waddr   = full ? oldest_q : IDX_W'(fill_q);
  assign oldest_next = ((CNT_W'(oldest_q) + CNT_W'(1)) == len) ? '0 : oldest_q + 1'b1;

  assign sum_d = sum_q + SUM_W'(sample_q) - (full ? SUM_W'(rd_q) : '0);

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});
  assign rem_d = qbit ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];

  // sample ring, read data registered
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      ring[ram_waddr] <= sample_q;
    end
    rd_q <= ring[oldest_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_q <= sample_i;
        end
      end
      S_LOAD: begin
        neg_q <= sum_q[SUM_W-1];
        dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_q <= '0;
        den_q <= div_full_q ? len : fill_q;
      end
      S_DIV: begin
        dvd_q <= {dvd_q[SUM_W-2:0], qbit};
        rem_q <= rem_d;
        if (step_q == LAST_STEP) begin
          mean_q <= neg_q ? SAMPLE_BITS'(-{dvd_q[SUM_W-2:0], qbit})
                          : SAMPLE_BITS'({dvd_q[SUM_W-2:0], qbit});
        end
      end
      S_OUT: begin
        if (out_load) begin
          window_mean_o       <= mean_q;
          sample_minus_mean_o <= (SAMPLE_BITS+1)'(sample_q) - (SAMPLE_BITS+1)'(mean_q);
          mean_change_o       <= (SAMPLE_BITS+1)'(mean_q) - (SAMPLE_BITS+1)'(prev_mean_q);
          window_full_o       <= full;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= WINDOW_RESET;
      div_full_q  <= 1'b0;
      fill_q      <= '0;
      oldest_q    <= '0;
      sum_q       <= '0;
      prev_mean_q <= '0;
      step_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          sum_q <= sum_d;
          if (full) begin
            oldest_q <= oldest_next;
          end else begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            prev_mean_q <= mean_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_WINDOW_LENGTH: begin
            wlen_q   <= cfg_data_i;
            fill_q   <= '0;
            oldest_q <= '0;
            sum_q    <= '0;
          end
          REG_DIVIDE_FULL: div_full_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/swmt_checker.sv
// swmt_checker: port-level assertions for the sliding window mean tracker
// depends on swmt_pkg; bound to sliding_window_mean_tracker_unit below
`default_nettype none

module swmt_checker
  import swmt_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [SAMPLE_BITS-1:0] window_mean_o,
  input wire logic signed [SAMPLE_BITS:0]   sample_minus_mean_o,
  input wire logic signed [SAMPLE_BITS:0]   mean_change_o,
  input wire logic                          window_full_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned WinBits = $clog2(MAX_WINDOW);

  logic unused_ok;
  assign unused_ok = ^{sample_i, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i,
                       WinBits[0]};

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_mean_o)
      && $stable(sample_minus_mean_o) && $stable(mean_change_o) && $stable(window_full_o))
    else $error("result beat changed while stalled");

  // one sample in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a beat");

  // a new result only comes out of a busy period
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a busy period");

  // finishing a sample leaves its result pending
  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("returned to idle without a result");

endmodule

bind sliding_window_mean_tracker_unit swmt_checker #(
  .MAX_WINDOW (MAX_WINDOW),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swmt_checker (.*);

`default_nettype wire

FILE: tb/swmt_mean_checker.sv
// swmt_mean_checker: watches the sample, result and config channels of the mean tracker,
// keeps its own ring, running sum and previous mean, and compares every result beat
// depends on swmt_pkg; instantiated next to the block by tb
module swmt_mean_checker
  import swmt_pkg::*;
(
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire logic signed [SAMPLE_BITS_DEF-1:0] sample_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic signed [SAMPLE_BITS_DEF-1:0] window_mean_i,
  input  wire logic signed [SAMPLE_BITS_DEF:0]   sample_minus_mean_i,
  input  wire logic signed [SAMPLE_BITS_DEF:0]   mean_change_i,
  input  wire logic                              window_full_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]             cfg_data_i,
  output int unsigned                            fail_count_o,
  output int unsigned                            pending_o
);

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned MW          = MAX_WINDOW_DEF;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    longint mean;
    longint diff;
    longint change;
    bit     full;
  } mean_result_t;

  mean_result_t          expected_q[$];
  longint                window_ring[MW];
  int unsigned           oldest_slot;
  int unsigned           fill_count;
  longint                window_sum;
  longint                last_mean;
  logic [CFG_DATA_W-1:0] window_length;
  bit                    divide_full;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count_o < MAX_REPORTS) begin
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  function automatic void clear_window();
    oldest_slot = 0;
    fill_count  = 0;
    window_sum  = 0;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW_LENGTH: begin
        window_length = data;
        clear_window();
      end
      REG_DIVIDE_FULL: divide_full = data[0];
      default: ;
    endcase
  endfunction

  function automatic mean_result_t track_sample(input logic signed [SB-1:0] s);
    mean_result_t res;
    int unsigned  len;
    int unsigned  slot;
    int unsigned  den;
    longint       mean;
    if (window_length == 0) len = 1;
    else if (window_length > MW) len = MW;
    else len = window_length;
    if (fill_count < len) begin
      slot = (oldest_slot + fill_count) % len;
      window_ring[slot] = s;
      window_sum += s;
      fill_count++;
    end else begin
      slot = oldest_slot % len;
      window_sum -= window_ring[slot];
      window_ring[slot] = s;
      window_sum += s;
      oldest_slot = (slot + 1) % len;
    end
    den = divide_full ? len : fill_count;
    if (den == 0) den = 1;
    // signed division truncates toward zero
    mean = window_sum / longint'(den);
    res.mean   = mean;
    res.diff   = longint'(s) - mean;
    res.change = mean - last_mean;
    res.full   = (fill_count == len);
    last_mean  = mean;
    return res;
  endfunction

  task automatic check_result();
    mean_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result beat with no sample pending", window_mean_i, 0);
    end else begin
      want = expected_q.pop_front();
      if (window_mean_i !== want.mean[SB-1:0])
        report_mismatch("window_mean", window_mean_i, want.mean);
      if (sample_minus_mean_i !== want.diff[SB:0])
        report_mismatch("sample_minus_mean", sample_minus_mean_i, want.diff);
      if (mean_change_i !== want.change[SB:0])
        report_mismatch("mean_change", mean_change_i, want.change);
      if (window_full_i !== want.full)
        report_mismatch("window_full", window_full_i, want.full);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_window();
      last_mean     = 0;
      window_length = WINDOW_RESET;
      divide_full   = 1'b0;
      fail_count_o  = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_config(cfg_index_i, cfg_data_i);
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) expected_q.push_back(track_sample(sample_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
// tb: top of the mean tracker testbench; drives sample beats, config writes and output
// stalls, and gives the verdict from the failure count of swmt_mean_checker
// depends on swmt_pkg, sliding_window_mean_tracker_unit and swmt_mean_checker
module tb;
  import swmt_pkg::*;

  localparam int unsigned SB           = SAMPLE_BITS_DEF;
  localparam int unsigned ITEM_TARGET  = 1500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam logic [SB-1:0]        SAMPLE_MAX       = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]        SAMPLE_MIN       = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic signed [SB-1:0]   sample_i    = '0;
  logic                   out_ready_i = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic signed [SB-1:0]   window_mean_o;
  logic signed [SB:0]     sample_minus_mean_o;
  logic signed [SB:0]     mean_change_o;
  logic                   window_full_o;
  logic                   cfg_ready_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles  = 0;
  int unsigned samples_sent = 0;
  int unsigned stall_left   = 0;
  bit          calm         = 1'b0;

  sliding_window_mean_tracker_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .window_mean_o       (window_mean_o),
    .sample_minus_mean_o (sample_minus_mean_o),
    .mean_change_o       (mean_change_o),
    .window_full_o       (window_full_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  swmt_mean_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .sample_i            (sample_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .window_mean_i       (window_mean_o),
    .sample_minus_mean_i (sample_minus_mean_o),
    .mean_change_i       (mean_change_o),
    .window_full_i       (window_full_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int unsigned r;
    int          near_zero;
    r = $urandom_range(0, 9);
    near_zero = int'($urandom_range(0, 2047)) - 1024;
    case (r)
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return near_zero[SB-1:0];
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(MAX_WINDOW_DEF);
      3:       return '1;
      4:       return CFG_DATA_W'(2);
      5, 6:    return CFG_DATA_W'($urandom_range(3, 20));
      default: return CFG_DATA_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_sample(input logic [SB-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // hold the sender until every result beat has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic cfg_end();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase();
    int unsigned count;
    int unsigned op;
    count = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 400) : $urandom_range(10, 100);
    op    = $urandom_range(0, 5);
    calm  = ($urandom_range(0, 4) == 0);
    wait_idle();
    if (op == 0) begin
      // divisor mode only, window keeps its contents
      cfg_put(REG_DIVIDE_FULL, CFG_DATA_W'($urandom()));
    end else begin
      if (op == 1) begin
        cfg_put(CFG_IDX_W'($urandom_range(REG_DIVIDE_FULL + 1, REG_UNMAPPED_TOP)),
                CFG_DATA_W'($urandom()));
      end
      cfg_put(REG_WINDOW_LENGTH, pick_length());
      cfg_put(REG_DIVIDE_FULL, CFG_DATA_W'($urandom_range(0, 1)));
    end
    cfg_end();
    repeat (count) begin
      send_sample(pick_sample());
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window of 20, divide by fill count
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SB'(-1));
    send_sample(SB'(1));
    send_sample('0);
    send_sample(SB'(-3));

    // zero length acts as one, mean swings between the extremes
    wait_idle();
    cfg_put(REG_WINDOW_LENGTH, '0);
    cfg_put(REG_DIVIDE_FULL, CFG_DATA_W'(1));
    cfg_end();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // length above the maximum saturates, full-window divide while filling
    wait_idle();
    cfg_put(REG_WINDOW_LENGTH, '1);
    cfg_end();
    send_sample(SAMPLE_MIN);
    send_sample(SB'(-7));
    send_sample(SB'(5));

    // unmapped index is ignored, divisor change keeps the window
    wait_idle();
    cfg_put(REG_UNMAPPED_TOP, '1);
    cfg_put(REG_DIVIDE_FULL, '0);
    cfg_end();
    send_sample(SB'(-3));
    send_sample(SB'(2));

    // short window wraps the ring
    wait_idle();
    cfg_put(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
    cfg_end();
    send_sample(SB'(7));
    send_sample(SB'(-8));
    send_sample(SB'(9));
    send_sample(SB'(-10));
    send_sample(SB'(11));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    while (samples_sent < ITEM_TARGET) run_phase();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
